/* rtl/md5he_pkg.sv */
// md5he_pkg: shared types, constants and round tables for the md5 hash engine
// no dependencies; imported by md5_hash_engine_top
package md5he_pkg;

    localparam int WordW = 32;
    localparam int AddrW = 4;
    localparam int Depth = 16;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_FIRST,
        S_PAD_ZERO,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } md5he_state_t;

    // where to go once a block has been compressed
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD_FIRST,
        RET_PAD_ZERO,
        RET_DIGEST
    } md5he_ret_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // message word used by round i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0:    g = i[3:0];
                2'd1:    g = 4'(5 * i[3:0] + 1);
                2'd2:    g = 4'(3 * i[3:0] + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            case (phase)
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (b & d) | (c & ~d);
                2'd2:    f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            return f;
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] w;
        begin
            w = {v, v} << s;
            return w[63:32];
        end
    endfunction

endpackage

/* rtl/md5_hash_engine_top.sv */
// md5_hash_engine_top: streaming md5 hasher, one byte per transfer, digest as four words
// depends on md5he_pkg
//
// Bytes are taken one per cycle while a block fills; input stall rises after every
// 64th byte while the shared round unit runs the 64 rounds out of the block memory
// (a load step, the round steps, a chaining add). An end transfer adds the padding
// words for the rest of the block, one or two compressions, then four output
// transfers A, B, C, D; input stays stalled until the
// last digest word has been taken. Message words live in a 16 x 32 synchronous memory
// written a whole word at a time; the round unit reads word g(i+1) while round i runs.
module md5_hash_engine_top
    import md5he_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    md5he_state_t state_reg, state_next;
    md5he_ret_t   ret_reg, ret_next;

    logic [63:0]  total_reg, total_next;
    logic [23:0]  part_reg, part_next;
    logic [AddrW-1:0] wptr_reg, wptr_next;
    logic         lenblk_reg, lenblk_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [1:0]   oidx_reg, oidx_next;
    logic [31:0]  chain_reg [4];
    logic [31:0]  chain_next [4];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  a_next, b_next, c_next, d_next;

    logic [WordW-1:0] mem [Depth];
    logic [WordW-1:0] mem_rdata;
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr, mem_raddr;
    logic [WordW-1:0] mem_wdata;

    logic        in_fire, out_fire;
    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] first_word, round_sum, new_b;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign digest_word = chain_reg[oidx_reg];
    assign word_index = oidx_reg;
    assign last_word = (oidx_reg == 2'd3);
    assign pos = total_reg[5:0];
    assign bit_len = {total_reg[60:0], 3'b000};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_rdata <= mem[mem_raddr];
    end

    // partial bytes below the pad lane, then the 0x80 marker, zeros above
    always_comb
    begin
        first_word = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (j < int'(pos[1:0]))
            begin
                if (j < 3)
                begin
                    first_word[j*8 +: 8] = part_reg[j*8 +: 8];
                end
            end
            else if (j == int'(pos[1:0]))
            begin
                first_word[j*8 +: 8] = PadByte;
            end
        end
    end

    always_comb
    begin
        round_sum = a_reg + round_f(rnd_reg[5:4], b_reg, c_reg, d_reg) + round_k(rnd_reg)
                    + mem_rdata;
        new_b = b_reg + rotl32(round_sum, rot_amount(rnd_reg));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_byte && pos == 6'd63)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (is_last)
                    begin
                        state_next = S_PAD_FIRST;
                    end
                end
            end
            S_PAD_FIRST:
            begin
                state_next = (pos[5:2] == 4'd15) ? S_LOAD : S_PAD_ZERO;
            end
            S_PAD_ZERO:
            begin
                if (wptr_reg == 4'd15)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                case (ret_reg)
                    RET_IDLE:      state_next = S_IDLE;
                    RET_PAD_FIRST: state_next = S_PAD_FIRST;
                    RET_PAD_ZERO:  state_next = S_PAD_ZERO;
                    default:       state_next = S_OUT;
                endcase
            end
            S_OUT:
            begin
                if (out_fire && oidx_reg == 2'd3)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ret_next = ret_reg;
        total_next = total_reg;
        part_next = part_reg;
        wptr_next = wptr_reg;
        lenblk_next = lenblk_reg;
        rnd_next = rnd_reg;
        oidx_next = oidx_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        for (int k = 0; k < 4; k++)
        begin
            chain_next[k] = chain_reg[k];
        end
        mem_we = 1'b0;
        mem_waddr = wptr_reg;
        mem_wdata = '0;
        mem_raddr = msg_index(rnd_reg + 6'd1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && has_byte)
                begin
                    total_next = total_reg + 64'd1;
                    case (pos[1:0])
                        2'd0: part_next[7:0] = data_byte;
                        2'd1: part_next[15:8] = data_byte;
                        2'd2: part_next[23:16] = data_byte;
                        default:
                        begin
                            mem_we = 1'b1;
                            mem_waddr = pos[5:2];
                            mem_wdata = {data_byte, part_reg};
                        end
                    endcase
                    if (pos == 6'd63)
                    begin
                        ret_next = is_last ? RET_PAD_FIRST : RET_IDLE;
                    end
                end
            end
            S_PAD_FIRST:
            begin
                mem_we = 1'b1;
                mem_waddr = pos[5:2];
                mem_wdata = first_word;
                wptr_next = pos[5:2] + 4'd1;
                lenblk_next = (pos[5:2] < 4'd14);
                ret_next = (pos[5:2] < 4'd14) ? RET_DIGEST : RET_PAD_ZERO;
            end
            S_PAD_ZERO:
            begin
                mem_we = 1'b1;
                mem_waddr = wptr_reg;
                if (lenblk_reg && wptr_reg == 4'd14)
                begin
                    mem_wdata = bit_len[31:0];
                end
                else if (lenblk_reg && wptr_reg == 4'd15)
                begin
                    mem_wdata = bit_len[63:32];
                end
                wptr_next = wptr_reg + 4'd1;
            end
            S_LOAD:
            begin
                mem_raddr = msg_index(6'd0);
                rnd_next = '0;
                a_next = chain_reg[0];
                b_next = chain_reg[1];
                c_next = chain_reg[2];
                d_next = chain_reg[3];
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                a_next = d_reg;
                d_next = c_reg;
                c_next = b_reg;
                b_next = new_b;
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (ret_reg == RET_PAD_ZERO)
                begin
                    // extra block: zeros from word 0, length at the end
                    wptr_next = '0;
                    lenblk_next = 1'b1;
                    ret_next = RET_DIGEST;
                end
                oidx_next = '0;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3)
                    begin
                        total_next = '0;
                        chain_next[0] = InitA;
                        chain_next[1] = InitB;
                        chain_next[2] = InitC;
                        chain_next[3] = InitD;
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= RET_IDLE;
            total_reg <= '0;
            wptr_reg <= '0;
            lenblk_reg <= 1'b0;
            rnd_reg <= '0;
            oidx_reg <= '0;
            chain_reg[0] <= InitA;
            chain_reg[1] <= InitB;
            chain_reg[2] <= InitC;
            chain_reg[3] <= InitD;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            total_reg <= total_next;
            wptr_reg <= wptr_next;
            lenblk_reg <= lenblk_next;
            rnd_reg <= rnd_next;
            oidx_reg <= oidx_next;
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while digest pending");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> (state_reg == S_ADD))
        else $error("round loop did not end after 64 rounds");

    a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 2'd0))
        else $error("digest did not start at word A");

    a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_word) |=> (!out_valid && total_reg == 64'd0))
        else $error("engine not cleared after last digest word");

endmodule

/* verif/tb_md5_hash_engine_top.sv */
// testbench for md5_hash_engine_top: directed and random byte streams, digests checked against a local md5 model
// depends on md5he_pkg and rtl/md5_hash_engine_top.sv
`timescale 1ns / 100ps

module tb_md5_hash_engine_top;
    import md5he_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam int CycleLimit = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    byte_item_t   pending_bytes[$];
    digest_item_t digest_queue[$];

    logic [31:0] msg_words[16];
    logic [31:0] chain[4];
    logic [63:0] byte_count;

    int  mismatch_count;
    int  cycle_count;
    bit  calm;
    int  in_gap;
    int  out_gap;
    int  hold_cycles;

    md5_hash_engine_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic int rot_of(input int i);
        int rots[16];
        rots = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        return rots[((i >> 4) << 2) | (i & 3)];
    endfunction

    function automatic logic [31:0] sine_const(input int i);
        logic [31:0] kt[64];
        kt = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return kt[i];
    endfunction

    task automatic compress_words();
        logic [31:0] a, b, c, d, f, sum, nb;
        int g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i >> 4)
                0:       begin f = (b & c) | (~b & d); g = i; end
                1:       begin f = (b & d) | (c & ~d); g = (5 * i + 1) & 15; end
                2:       begin f = b ^ c ^ d;          g = (3 * i + 5) & 15; end
                default: begin f = c ^ (b | ~d);       g = (7 * i) & 15; end
            endcase
            sum = a + f + sine_const(i) + msg_words[g];
            nb = b + rol(sum, rot_of(i));
            a = d;
            d = c;
            c = b;
            b = nb;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic put_lane(input int pos, input logic [7:0] v);
        msg_words[(pos >> 2) & 15][(pos & 3) * 8 +: 8] = v;
    endtask

    task automatic clear_hash();
        chain[0] = InitA;
        chain[1] = InitB;
        chain[2] = InitC;
        chain[3] = InitD;
        byte_count = '0;
        for (int i = 0; i < 16; i++)
            msg_words[i] = '0;
    endtask

    // advance the local hash by one accepted transfer, queue the digest on an end
    task automatic hash_item(input byte_item_t it);
        int pos;
        logic [63:0] bits;
        digest_item_t r;
        if (it.has_byte)
        begin
            pos = int'(byte_count[5:0]);
            put_lane(pos, it.data_byte);
            byte_count++;
            if (pos == 63)
                compress_words();
        end
        if (it.is_last)
        begin
            bits = byte_count << 3;
            pos = int'(byte_count[5:0]);
            put_lane(pos, PadByte);
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    put_lane(pos, 8'h00);
                    pos++;
                end
                compress_words();
                pos = 0;
            end
            while (pos < 56)
            begin
                put_lane(pos, 8'h00);
                pos++;
            end
            msg_words[14] = bits[31:0];
            msg_words[15] = bits[63:32];
            compress_words();
            for (int k = 0; k < 4; k++)
            begin
                r.digest_word = chain[k];
                r.word_index = 2'(k);
                r.last_word = (k == 3);
                digest_queue.push_back(r);
            end
            clear_hash();
        end
    endtask

    task automatic add_item(input logic [7:0] d, input bit hb, input bit lst);
        byte_item_t it;
        it.data_byte = d;
        it.has_byte = hb;
        it.is_last = lst;
        pending_bytes.push_back(it);
    endtask

    task automatic add_message(input int len, input bit end_with_byte, input bit sprinkle_idle);
        for (int i = 0; i < len; i++)
        begin
            if (sprinkle_idle && $urandom_range(0, 9) == 0)
                add_item(8'($urandom), 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
        end
        if (!end_with_byte || len == 0)
            add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            has_byte <= 1'b0;
            is_last <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                hash_item(pending_bytes.pop_front());
            end
            if (in_valid && in_stall)
            begin
                // payload held while stalled
            end
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                if (!calm && $urandom_range(0, 15) == 0)
                begin
                    in_gap <= $urandom_range(1, 17) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    data_byte <= pending_bytes[0].data_byte;
                    has_byte <= pending_bytes[0].has_byte;
                    is_last <= pending_bytes[0].is_last;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold right after reset while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 600;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected digest word %h index %0d", digest_word, word_index);
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (want.digest_word !== digest_word || want.word_index !== word_index ||
                        want.last_word !== last_word)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     want.digest_word, want.word_index, want.last_word,
                                     digest_word, word_index, last_word);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(1, 17) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int len;
        mismatch_count = 0;
        cycle_count = 0;
        calm = 0;
        clear_hash();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, extremes, byte with end, 55/56/63/64 byte tails
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h5a, 1'b0, 1'b1);
        add_item(8'ha5, 1'b1, 1'b1);

        add_message(56, 1'b1, 1'b0);
        add_message(55, 1'b0, 1'b0);
        add_message(63, 1'b1, 1'b0);
        add_message(64, 1'b0, 1'b1);

        // random messages, mostly short with a few block boundaries
        while (pending_bytes.size() < 300)
        begin
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(0, 12);
            add_message(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        wait (pending_bytes.size() < 60);
        calm = 1;
        wait (pending_bytes.size() == 0);
        @(posedge clk);
        wait (digest_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && digest_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
